// ===== sv/c8x_pkg.sv =====
// Shared types, opcode codes and constants for the CHIP-8 instruction execute core.
`default_nettype none
package c8x_pkg;

    localparam int C_STACK_DEPTH = 16;
    localparam int C_NUM_VREGS   = 16;
    localparam int C_PC_W        = 12;
    localparam int C_VREG_W      = 8;
    localparam int C_VNUM_W      = 4;

    localparam logic [C_PC_W-1:0]   C_PC_RESET = 12'h200;
    localparam logic [C_VNUM_W-1:0] C_VF_NUM   = 4'hF;

    localparam logic [15:0] INS_CLS = 16'h00E0;
    localparam logic [15:0] INS_RET = 16'h00EE;

    localparam logic [3:0] OP_SYS  = 4'h0;
    localparam logic [3:0] OP_JP   = 4'h1;
    localparam logic [3:0] OP_CALL = 4'h2;
    localparam logic [3:0] OP_SEI  = 4'h3;
    localparam logic [3:0] OP_SNEI = 4'h4;
    localparam logic [3:0] OP_SER  = 4'h5;
    localparam logic [3:0] OP_LDI  = 4'h6;
    localparam logic [3:0] OP_ADDI = 4'h7;
    localparam logic [3:0] OP_ALU  = 4'h8;
    localparam logic [3:0] OP_SNER = 4'h9;
    localparam logic [3:0] OP_LDIX = 4'hA;

    localparam logic [3:0] ALU_LD   = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    typedef struct packed {
        logic                bad;
        logic                cls;
        logic [C_PC_W-1:0]   pc;
        logic [C_PC_W-1:0]   idx;
        logic                push;
        logic                pop;
        logic                v_we;
        logic [C_VNUM_W-1:0] v_num;
        logic [C_VREG_W-1:0] v_val;
        logic [C_VREG_W-1:0] vf;
    } t_exec;

endpackage
`default_nettype wire

// ===== sv/chip8_instruction_execute_core.sv =====
// Top level of the CHIP-8 instruction execute core: handshakes, state registers and result register.
`default_nettype none
// Executes one 16-bit CHIP-8 instruction word per transfer and returns one result per
// instruction: the new program counter, index register, VF, the V register written and the
// clear-display and unsupported indications. An instruction is taken into an input register,
// where its Vx and Vy operands are read from the register file, and is executed from there
// into the result register once the output can take a result, so one instruction can be taken
// every cycle while the output is not stalled. The register file's read ports are registered;
// a write from the instruction in execute is forwarded to the operands of the one behind it.
// The return stack keeps its top entry in a register, read ahead from the stack memory each
// cycle. Reset returns PC to 0x200 and clears all other state at once; no clearing pass is needed.
module chip8_instruction_execute_core
    import c8x_pkg::*;
#(
    parameter int STACK_DEPTH = C_STACK_DEPTH
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [15:0]         i_instruction,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic      [C_PC_W-1:0]   o_next_pc,
    output logic      [C_PC_W-1:0]   o_index_value,
    output logic                     o_clear_display,
    output logic                     o_reg_written,
    output logic      [C_VNUM_W-1:0] o_reg_number,
    output logic      [C_VREG_W-1:0] o_reg_value,
    output logic      [C_VREG_W-1:0] o_flag_value,
    output logic                     o_unsupported
);

    logic                r_in_vld;
    logic [15:0]         r_ins;
    logic                r_out_vld;
    logic [C_PC_W-1:0]   r_pc;
    logic [C_PC_W-1:0]   r_idx;
    logic                fire;
    logic                accept;
    logic [C_VREG_W-1:0] vx_rd;
    logic [C_VREG_W-1:0] vy_rd;
    logic [C_VREG_W-1:0] vf;
    logic [C_PC_W-1:0]   top;
    logic                vmem_we;
    t_exec               ex;
    t_exec               r_res;

    assign fire       = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !fire;
    assign accept     = i_in_valid && !o_in_stall;
    assign vmem_we    = fire && ex.v_we && ex.v_num != C_VF_NUM;

    c8x_vregs u_vregs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (accept),
        .i_rd_x   (i_instruction[11:8]),
        .i_rd_y   (i_instruction[7:4]),
        .i_wr_en  (vmem_we),
        .i_wr_num (ex.v_num),
        .i_wr_val (ex.v_val),
        .i_vf_en  (fire),
        .i_vf_val (ex.vf),
        .o_vx     (vx_rd),
        .o_vy     (vy_rd),
        .o_vf     (vf)
    );

    c8x_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire && ex.push),
        .i_pop   (fire && ex.pop),
        .i_wdata (r_pc + 12'd2),
        .o_top   (top)
    );

    c8x_exec u_exec (
        .i_ins   (r_ins),
        .i_vx_rd (vx_rd),
        .i_vy_rd (vy_rd),
        .i_vf    (vf),
        .i_pc    (r_pc),
        .i_idx   (r_idx),
        .i_top   (top),
        .o_ex    (ex)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ins <= i_instruction;
        end
        if (fire) begin
            r_res <= ex;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_pc      <= C_PC_RESET;
            r_idx     <= '0;
        end else begin
            if (accept) begin
                r_in_vld <= 1'b1;
            end else if (fire) begin
                r_in_vld <= 1'b0;
            end
            if (fire) begin
                r_out_vld <= 1'b1;
                r_pc      <= ex.pc;
                r_idx     <= ex.idx;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_next_pc       = r_res.pc;
    assign o_index_value   = r_res.idx;
    assign o_clear_display = r_res.cls;
    assign o_reg_written   = r_res.v_we;
    assign o_reg_number    = r_res.v_num;
    assign o_reg_value     = r_res.v_val;
    assign o_flag_value    = r_res.vf;
    assign o_unsupported   = r_res.bad;

    a_bad_keeps_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && ex.bad) |=> (r_pc == $past(r_pc)))
        else $error("unsupported instruction changed the program counter");

    a_out_pc_is_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> (o_next_pc == r_pc && o_index_value == r_idx))
        else $error("result does not match the architectural state");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_reg_written) |-> (o_reg_number == '0 && o_reg_value == '0))
        else $error("register fields nonzero without a register write");

    a_stack_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |-> !(ex.push && ex.pop) && !(ex.bad && (ex.push || ex.pop || ex.v_we)))
        else $error("conflicting stack or register update");

endmodule
`default_nettype wire

// ===== sv/c8x_vregs.sv =====
// V register file: a two-read, one-write memory for V0 to VE plus a separate VF register.
`default_nettype none
module c8x_vregs
    import c8x_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_rd_en,
    input  wire logic [C_VNUM_W-1:0] i_rd_x,
    input  wire logic [C_VNUM_W-1:0] i_rd_y,
    input  wire logic                i_wr_en,
    input  wire logic [C_VNUM_W-1:0] i_wr_num,
    input  wire logic [C_VREG_W-1:0] i_wr_val,
    input  wire logic                i_vf_en,
    input  wire logic [C_VREG_W-1:0] i_vf_val,
    output logic      [C_VREG_W-1:0] o_vx,
    output logic      [C_VREG_W-1:0] o_vy,
    output logic      [C_VREG_W-1:0] o_vf
);

    logic [C_VREG_W-1:0]    r_mem [C_NUM_VREGS];
    logic [C_NUM_VREGS-1:0] r_mem_vld;
    logic [C_VREG_W-1:0]    r_vx;
    logic [C_VREG_W-1:0]    r_vy;
    logic [C_VREG_W-1:0]    r_vf;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_num] <= i_wr_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= '0;
            r_vf      <= '0;
        end else begin
            if (i_wr_en) begin
                r_mem_vld[i_wr_num] <= 1'b1;
            end
            if (i_vf_en) begin
                r_vf <= i_vf_val;
            end
        end
    end

    // A write from the instruction leaving execute is forwarded to the read of the next one.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && i_wr_num == i_rd_x) begin
                r_vx <= i_wr_val;
            end else if (r_mem_vld[i_rd_x]) begin
                r_vx <= r_mem[i_rd_x];
            end else begin
                r_vx <= '0;
            end
            if (i_wr_en && i_wr_num == i_rd_y) begin
                r_vy <= i_wr_val;
            end else if (r_mem_vld[i_rd_y]) begin
                r_vy <= r_mem[i_rd_y];
            end else begin
                r_vy <= '0;
            end
        end
    end

    assign o_vx = r_vx;
    assign o_vy = r_vy;
    assign o_vf = r_vf;

endmodule
`default_nettype wire

// ===== sv/c8x_stack.sv =====
// Return stack memory with its pointer and a registered top-of-stack entry.
`default_nettype none
module c8x_stack
    import c8x_pkg::*;
#(
    parameter int STACK_DEPTH = C_STACK_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic              i_pop,
    input  wire logic [C_PC_W-1:0] i_wdata,
    output logic      [C_PC_W-1:0] o_top
);

    localparam int SP_W = $clog2(STACK_DEPTH);
    localparam logic [SP_W-1:0] SP_LAST = SP_W'(STACK_DEPTH - 1);

    logic [C_PC_W-1:0]      r_mem [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] r_mem_vld;
    logic [SP_W-1:0]        r_sp;
    logic [SP_W-1:0]        n_sp;
    logic [SP_W-1:0]        rd_addr;
    logic [C_PC_W-1:0]      r_top;

    always_comb begin
        n_sp = r_sp;
        if (i_push) begin
            n_sp = (r_sp == SP_LAST) ? '0 : r_sp + 1'b1;
        end else if (i_pop) begin
            n_sp = (r_sp == '0) ? SP_LAST : r_sp - 1'b1;
        end
        rd_addr = (n_sp == '0) ? SP_LAST : n_sp - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_sp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp      <= '0;
            r_mem_vld <= '0;
            r_top     <= '0;
        end else begin
            r_sp <= n_sp;
            if (i_push) begin
                r_mem_vld[r_sp] <= 1'b1;
            end
            if (i_push && r_sp == rd_addr) begin
                r_top <= i_wdata;
            end else if (r_mem_vld[rd_addr]) begin
                r_top <= r_mem[rd_addr];
            end else begin
                r_top <= '0;
            end
        end
    end

    assign o_top = r_top;

endmodule
`default_nettype wire

// ===== sv/c8x_exec.sv =====
// Instruction decode, ALU and next-state computation for one instruction.
`default_nettype none
module c8x_exec
    import c8x_pkg::*;
(
    input  wire logic [15:0]         i_ins,
    input  wire logic [C_VREG_W-1:0] i_vx_rd,
    input  wire logic [C_VREG_W-1:0] i_vy_rd,
    input  wire logic [C_VREG_W-1:0] i_vf,
    input  wire logic [C_PC_W-1:0]   i_pc,
    input  wire logic [C_PC_W-1:0]   i_idx,
    input  wire logic [C_PC_W-1:0]   i_top,
    output t_exec                    o_ex
);

    logic [3:0]          op;
    logic [C_VNUM_W-1:0] x;
    logic [C_VNUM_W-1:0] y;
    logic [3:0]          n;
    logic [C_VREG_W-1:0] kk;
    logic [C_PC_W-1:0]   nnn;
    logic [C_VREG_W-1:0] vx;
    logic [C_VREG_W-1:0] vy;
    logic [C_PC_W-1:0]   pc2;
    logic [C_PC_W-1:0]   pc4;
    logic [C_VREG_W:0]   sum;
    logic                f_we;
    logic [C_VREG_W-1:0] flag;
    logic [C_VREG_W-1:0] ax;
    logic [C_VREG_W-1:0] ay;
    t_exec               e;

    always_comb begin
        op   = i_ins[15:12];
        x    = i_ins[11:8];
        y    = i_ins[7:4];
        n    = i_ins[3:0];
        kk   = i_ins[7:0];
        nnn  = i_ins[11:0];
        vx   = (x == C_VF_NUM) ? i_vf : i_vx_rd;
        vy   = (y == C_VF_NUM) ? i_vf : i_vy_rd;
        pc2  = i_pc + 12'd2;
        pc4  = i_pc + 12'd4;
        sum  = {1'b0, vx} + {1'b0, vy};
        f_we = 1'b0;
        flag = '0;
        ax   = vx;
        ay   = vy;

        e     = '0;
        e.pc  = pc2;
        e.idx = i_idx;

        unique case (op)
            OP_SYS: begin
                if (i_ins == INS_CLS) begin
                    e.cls = 1'b1;
                end else if (i_ins == INS_RET) begin
                    e.pop = 1'b1;
                    e.pc  = i_top;
                end else begin
                    e.bad = 1'b1;
                end
            end
            OP_JP: e.pc = nnn;
            OP_CALL: begin
                e.push = 1'b1;
                e.pc   = nnn;
            end
            OP_SEI: begin
                if (vx == kk) begin
                    e.pc = pc4;
                end
            end
            OP_SNEI: begin
                if (vx != kk) begin
                    e.pc = pc4;
                end
            end
            OP_SER: begin
                if (n != 4'h0) begin
                    e.bad = 1'b1;
                end else if (vx == vy) begin
                    e.pc = pc4;
                end
            end
            OP_LDI: begin
                e.v_we  = 1'b1;
                e.v_num = x;
                e.v_val = kk;
            end
            OP_ADDI: begin
                e.v_we  = 1'b1;
                e.v_num = x;
                e.v_val = vx + kk;
            end
            OP_ALU: begin
                e.v_we  = 1'b1;
                e.v_num = x;
                // The flag is written before the result; a VF operand of SUB, SHR, SUBN or SHL sees the new flag.
                unique case (n)
                    ALU_LD:  e.v_val = vy;
                    ALU_OR:  e.v_val = vx | vy;
                    ALU_AND: e.v_val = vx & vy;
                    ALU_ADD: begin
                        f_we    = 1'b1;
                        flag    = {7'b0, sum[C_VREG_W]};
                        e.v_val = sum[C_VREG_W-1:0];
                    end
                    ALU_SUB: begin
                        f_we    = 1'b1;
                        flag    = {7'b0, vx > vy};
                        ax      = (x == C_VF_NUM) ? flag : vx;
                        ay      = (y == C_VF_NUM) ? flag : vy;
                        e.v_val = ax - ay;
                    end
                    ALU_SHR: begin
                        f_we    = 1'b1;
                        flag    = {7'b0, vx[0]};
                        ax      = (x == C_VF_NUM) ? flag : vx;
                        e.v_val = ax >> 1;
                    end
                    ALU_SUBN: begin
                        f_we    = 1'b1;
                        flag    = {7'b0, vy > vx};
                        ax      = (x == C_VF_NUM) ? flag : vx;
                        ay      = (y == C_VF_NUM) ? flag : vy;
                        e.v_val = ay - ax;
                    end
                    ALU_SHL: begin
                        f_we    = 1'b1;
                        flag    = {7'b0, vx[7]};
                        ax      = (x == C_VF_NUM) ? flag : vx;
                        e.v_val = ax << 1;
                    end
                    default: begin
                        e.v_we  = 1'b0;
                        e.v_num = '0;
                        e.bad   = 1'b1;
                    end
                endcase
            end
            OP_SNER: begin
                if (n != 4'h0) begin
                    e.bad = 1'b1;
                end else if (vx != vy) begin
                    e.pc = pc4;
                end
            end
            OP_LDIX: e.idx = nnn;
            default: e.bad = 1'b1;
        endcase

        if (e.bad) begin
            e.pc = i_pc;
        end

        if (e.v_we && e.v_num == C_VF_NUM) begin
            e.vf = e.v_val;
        end else if (f_we) begin
            e.vf = flag;
        end else begin
            e.vf = i_vf;
        end

        o_ex = e;
    end

endmodule
`default_nettype wire

// ===== sim/tb_chip8_instruction_execute_core.sv =====
// Testbench for the CHIP-8 instruction execute core: directed and random instruction streams.
`timescale 1ns / 100ps
module tb_chip8_instruction_execute_core;
    import c8x_pkg::*;

    localparam int LONG_HOLD = 120;

    typedef struct {
        logic [C_PC_W-1:0]   next_pc;
        logic [C_PC_W-1:0]   index_value;
        logic                clear_display;
        logic                reg_written;
        logic [C_VNUM_W-1:0] reg_number;
        logic [C_VREG_W-1:0] reg_value;
        logic [C_VREG_W-1:0] flag_value;
        logic                unsupported;
    } t_exec_result;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [15:0]         i_instruction = 16'h0000;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [C_PC_W-1:0]   o_next_pc;
    logic [C_PC_W-1:0]   o_index_value;
    logic                o_clear_display;
    logic                o_reg_written;
    logic [C_VNUM_W-1:0] o_reg_number;
    logic [C_VREG_W-1:0] o_reg_value;
    logic [C_VREG_W-1:0] o_flag_value;
    logic                o_unsupported;

    logic [15:0]   instr_queue[$];
    t_exec_result  exec_results[$];
    t_exec_result  oldest;

    logic [C_VREG_W-1:0] vreg [C_NUM_VREGS];
    logic [C_PC_W-1:0]   ret_stack [C_STACK_DEPTH];
    logic [C_PC_W-1:0]   cur_pc = C_PC_RESET;
    logic [C_PC_W-1:0]   index_reg = '0;
    int                  stack_ptr = 0;

    int   n_accepted = 0;
    int   n_checked = 0;
    int   n_errors = 0;
    int   n_unsupported = 0;
    int   n_reg_writes = 0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   hold_cycles = 0;
    int   rx_cycle = 0;
    logic calm = 1'b0;

    chip8_instruction_execute_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_instruction   (i_instruction),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_next_pc       (o_next_pc),
        .o_index_value   (o_index_value),
        .o_clear_display (o_clear_display),
        .o_reg_written   (o_reg_written),
        .o_reg_number    (o_reg_number),
        .o_reg_value     (o_reg_value),
        .o_flag_value    (o_flag_value),
        .o_unsupported   (o_unsupported)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        foreach (vreg[i]) vreg[i] = '0;
        foreach (ret_stack[i]) ret_stack[i] = '0;
    end

    task automatic write_vreg(inout t_exec_result r, input logic [3:0] num,
                              input logic [7:0] val);
        vreg[num] = val;
        r.reg_written = 1'b1;
        r.reg_number = num;
        r.reg_value = val;
    endtask

    task automatic run_instruction(input logic [15:0] ins);
        logic [3:0]  op;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [3:0]  n;
        logic [7:0]  kk;
        logic [11:0] nnn;
        logic [11:0] pc;
        logic [8:0]  sum;
        int          sp;
        t_exec_result r;
        op = ins[15:12];
        x = ins[11:8];
        y = ins[7:4];
        n = ins[3:0];
        kk = ins[7:0];
        nnn = ins[11:0];
        pc = cur_pc + 12'd2;
        sp = stack_ptr;
        r = '{default: '0};
        case (op)
            OP_SYS: begin
                if (ins == INS_CLS) begin
                    r.clear_display = 1'b1;
                end else if (ins == INS_RET) begin
                    sp = (sp == 0) ? C_STACK_DEPTH - 1 : sp - 1;
                    pc = ret_stack[sp];
                end else begin
                    r.unsupported = 1'b1;
                end
            end
            OP_JP: pc = nnn;
            OP_CALL: begin
                ret_stack[sp] = pc;
                sp = (sp + 1 >= C_STACK_DEPTH) ? 0 : sp + 1;
                pc = nnn;
            end
            OP_SEI: if (vreg[x] == kk) pc = pc + 12'd2;
            OP_SNEI: if (vreg[x] != kk) pc = pc + 12'd2;
            OP_SER: begin
                if (n != 4'h0) r.unsupported = 1'b1;
                else if (vreg[x] == vreg[y]) pc = pc + 12'd2;
            end
            OP_LDI: write_vreg(r, x, kk);
            OP_ADDI: write_vreg(r, x, vreg[x] + kk);
            OP_ALU: begin
                case (n)
                    ALU_LD: write_vreg(r, x, vreg[y]);
                    ALU_OR: write_vreg(r, x, vreg[x] | vreg[y]);
                    ALU_AND: write_vreg(r, x, vreg[x] & vreg[y]);
                    ALU_ADD: begin
                        sum = {1'b0, vreg[x]} + {1'b0, vreg[y]};
                        write_vreg(r, C_VF_NUM, {7'b0, sum[8]});
                        write_vreg(r, x, sum[7:0]);
                    end
                    ALU_SUB: begin
                        write_vreg(r, C_VF_NUM, {7'b0, vreg[x] > vreg[y]});
                        write_vreg(r, x, vreg[x] - vreg[y]);
                    end
                    ALU_SHR: begin
                        write_vreg(r, C_VF_NUM, {7'b0, vreg[x][0]});
                        write_vreg(r, x, {1'b0, vreg[x][7:1]});
                    end
                    ALU_SUBN: begin
                        write_vreg(r, C_VF_NUM, {7'b0, vreg[y] > vreg[x]});
                        write_vreg(r, x, vreg[y] - vreg[x]);
                    end
                    ALU_SHL: begin
                        write_vreg(r, C_VF_NUM, {7'b0, vreg[x][7]});
                        write_vreg(r, x, {vreg[x][6:0], 1'b0});
                    end
                    default: r.unsupported = 1'b1;
                endcase
            end
            OP_SNER: begin
                if (n != 4'h0) r.unsupported = 1'b1;
                else if (vreg[x] != vreg[y]) pc = pc + 12'd2;
            end
            OP_LDIX: index_reg = nnn;
            default: r.unsupported = 1'b1;
        endcase
        if (!r.unsupported) begin
            cur_pc = pc;
            stack_ptr = sp;
        end else begin
            n_unsupported++;
        end
        if (r.reg_written) n_reg_writes++;
        r.next_pc = cur_pc;
        r.index_value = index_reg;
        r.flag_value = vreg[C_VF_NUM];
        exec_results.push_back(r);
    endtask

    function automatic logic [15:0] rand_instruction();
        logic [3:0] x;
        logic [3:0] y;
        logic [3:0] alu;
        logic [7:0] kk;
        int         sel;
        x = 4'($urandom_range(0, 15));
        y = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 3))
            0: kk = 8'h00;
            1: kk = 8'hFF;
            2: kk = 8'($urandom_range(0, 3));
            default: kk = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 7))
            0: alu = ALU_LD;
            1: alu = ALU_OR;
            2: alu = ALU_AND;
            3: alu = ALU_ADD;
            4: alu = ALU_SUB;
            5: alu = ALU_SHR;
            6: alu = ALU_SUBN;
            default: alu = ALU_SHL;
        endcase
        sel = $urandom_range(0, 99);
        if (sel < 12) return {OP_LDI, x, kk};
        if (sel < 20) return {OP_ADDI, x, kk};
        if (sel < 50) return {OP_ALU, x, y, alu};
        if (sel < 56) return {OP_SEI, x, kk};
        if (sel < 62) return {OP_SNEI, x, kk};
        if (sel < 67) return {OP_SER, x, y, 4'h0};
        if (sel < 72) return {OP_SNER, x, y, 4'h0};
        if (sel < 75) return {OP_JP, 12'($urandom_range(0, 4095))};
        if (sel < 79) return {OP_CALL, 12'($urandom_range(0, 4095))};
        if (sel < 83) return INS_RET;
        if (sel < 85) return INS_CLS;
        if (sel < 88) return {OP_LDIX, 12'($urandom_range(0, 4095))};
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic check_field(input string name, input logic [11:0] want,
                               input logic [11:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                run_instruction(i_instruction);
                n_accepted <= n_accepted + 1;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (instr_queue.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_instruction <= instr_queue.pop_front();
                    if (!calm && (n_accepted / 40) % 3 != 0 && $urandom_range(0, 5) == 0)
                        gap_left <= $urandom_range(1, 13);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            calm <= (instr_queue.size() < 50);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (n_accepted >= 150 && hold_cycles < LONG_HOLD) begin
                hold_cycles <= hold_cycles + 1;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_out_stall <= 1'b1;
            end else if (!calm && (rx_cycle / 97) % 3 != 1 && $urandom_range(0, 7) == 0) begin
                stall_left <= $urandom_range(0, 12);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (exec_results.size() == 0) begin
                $error("result transfer with no instruction outstanding");
                n_errors++;
            end else begin
                oldest = exec_results.pop_front();
                check_field("next_pc", oldest.next_pc, o_next_pc);
                check_field("index_value", oldest.index_value, o_index_value);
                check_field("clear_display", 12'(oldest.clear_display), 12'(o_clear_display));
                check_field("reg_written", 12'(oldest.reg_written), 12'(o_reg_written));
                check_field("reg_number", 12'(oldest.reg_number), 12'(o_reg_number));
                check_field("reg_value", 12'(oldest.reg_value), 12'(o_reg_value));
                check_field("flag_value", 12'(oldest.flag_value), 12'(o_flag_value));
                check_field("unsupported", 12'(oldest.unsupported), 12'(o_unsupported));
                n_checked++;
            end
        end
    end

    initial begin
        instr_queue = '{
            INS_CLS,
            {OP_LDI, 4'h1, 8'hFF},
            {OP_LDI, 4'h2, 8'h01},
            {OP_ALU, 4'h1, 4'h2, ALU_ADD},
            {OP_ADDI, 4'h2, 8'hFF},
            {OP_ALU, 4'h2, 4'h1, ALU_SUB},
            {OP_LDI, 4'h3, 8'h80},
            {OP_ALU, 4'h3, 4'h3, ALU_SHL},
            {OP_ALU, 4'hF, 4'h3, ALU_SHR},
            {OP_ALU, 4'h4, 4'hF, ALU_SUBN},
            {OP_ALU, 4'h5, 4'h3, ALU_OR},
            {OP_ALU, 4'h5, 4'h1, ALU_AND},
            {OP_ALU, 4'hF, 4'h1, ALU_LD},
            {OP_ALU, 4'h1, 4'h2, 4'h3},
            {OP_SEI, 4'h3, 8'h00},
            {OP_SNEI, 4'h3, 8'h00},
            {OP_SER, 4'h1, 4'h3, 4'h0},
            {OP_SER, 4'h1, 4'h3, 4'h1},
            {OP_SNER, 4'h1, 4'h2, 4'h0},
            {OP_SNER, 4'h1, 4'h2, 4'hF},
            INS_RET,
            {OP_CALL, 12'hABC},
            INS_RET,
            {OP_JP, 12'hFFE},
            {OP_SEI, 4'h0, 8'h00},
            {OP_LDIX, 12'hFFF},
            16'hFFFF,
            16'h0123,
            16'h0000,
            16'hB000
        };
        for (int i = 0; i < 280; i++) instr_queue.push_back(rand_instruction());
        // Nest calls past the stack depth, then unwind past empty.
        for (int i = 0; i < C_STACK_DEPTH + 2; i++)
            instr_queue.push_back({OP_CALL, 12'($urandom_range(0, 4095))});
        for (int i = 0; i < C_STACK_DEPTH + 2; i++) instr_queue.push_back(INS_RET);
        for (int i = 0; i < 280; i++) instr_queue.push_back(rand_instruction());

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (instr_queue.size() != 0 || i_in_valid) @(posedge i_clk);
        while (exec_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Executed %0d instruction transfers (%0d unsupported, %0d register writes).",
                 n_accepted, n_unsupported, n_reg_writes);
        $display("Checked %0d result transfers, including a %0d-cycle output hold-off.",
                 n_checked, LONG_HOLD);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d results outstanding.", exec_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
sv/c8x_pkg.sv
sv/c8x_vregs.sv
sv/c8x_stack.sv
sv/c8x_exec.sv
sv/chip8_instruction_execute_core.sv
sim/tb_chip8_instruction_execute_core.sv
